FILE: rtl/kbc_pkg.sv
// Shared types and constants of the keyed block cache: field widths, request
// and response codes, sequencer states and the per-cell control bundle.
// No dependencies.
package kbc_pkg;

   localparam int CAPACITY_DEF   = 8;
   localparam int KEY_WIDTH_DEF  = 32;
   localparam int DATA_BYTES_DEF = 4;

   localparam int ACTION_W    = 2;
   localparam int KEY_FIELD_W = 32;
   localparam int PAYLOAD_W   = 32;
   localparam int NBYTES_W    = 3;
   localparam int MASK_W      = 8;
   localparam int RIGHTS_W    = 32;
   localparam int STATUS_W    = 3;

   localparam int REQ_FIELDS_W = KEY_FIELD_W + PAYLOAD_W + NBYTES_W + MASK_W + RIGHTS_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = ACTION_W;
   localparam int RSP_FIELDS_W = PAYLOAD_W + NBYTES_W + MASK_W + RIGHTS_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W  = STATUS_W + 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_GET   = 2'd0,
      ACT_PUT   = 2'd1,
      ACT_INVAL = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_HIT          = 3'd0,
      RSP_MISS         = 3'd1,
      RSP_INSERTED     = 3'd2,
      RSP_EVICTED      = 3'd3,
      RSP_RIGHTS_INVAL = 3'd4,
      RSP_UNCHANGED    = 3'd5,
      RSP_INVALIDATED  = 3'd6,
      RSP_INVAL_MISS   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Per-cell strobes from the sequencer.
   typedef struct packed {
      logic cmp_en;   // register key compare results
      logic shift;    // take the entry of the next cell up
      logic load;     // take the new entry
      logic clear;    // drop the valid mark
   } cell_ctl_type;

endpackage

FILE: rtl/kbc_pick.sv
// First-set picker: isolates the lowest set bit of a match vector.
// Depends on nothing.
module kbc_pick #(
   parameter int N = 8
) (
   input  logic [N-1:0] match_vec,
   output logic [N-1:0] first_oh,
   output logic         any
);

   // Two's complement isolates the lowest set bit.
   assign first_oh = match_vec & (~match_vec + N'(1));
   assign any      = |match_vec;

endmodule

FILE: rtl/kbc_cell.sv
// One slot of the keyed block cache chain: holds an entry, compares its key,
// and shifts in the entry of its upper neighbor on eviction. Uses kbc_pkg.
module kbc_cell
   import kbc_pkg::*;
#(
   parameter int KW = 32,
   parameter int DW = 32
) (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic                occupied,
   input  logic [KW-1:0]       cmp_key,
   input  logic [RIGHTS_W-1:0] cmp_rights,
   input  logic [KW-1:0]       new_key,
   input  logic [DW-1:0]       new_data,
   input  logic [NBYTES_W-1:0] new_bytes,
   input  logic [MASK_W-1:0]   new_mask,
   input  logic [RIGHTS_W-1:0] new_rights,
   input  logic [KW-1:0]       nbr_key,
   input  logic [DW-1:0]       nbr_data,
   input  logic [NBYTES_W-1:0] nbr_bytes,
   input  logic [MASK_W-1:0]   nbr_mask,
   input  logic [RIGHTS_W-1:0] nbr_rights,
   input  logic                nbr_valid,
   output logic [KW-1:0]       key,
   output logic [DW-1:0]       data,
   output logic [NBYTES_W-1:0] nbytes,
   output logic [MASK_W-1:0]   mask,
   output logic [RIGHTS_W-1:0] rights,
   output logic                valid,
   output logic                match,
   output logic                hit,
   output logic                rights_eq
);

   logic [KW-1:0]       key_ff,    key_in;
   logic [DW-1:0]       data_ff,   data_in;
   logic [NBYTES_W-1:0] bytes_ff,  bytes_in;
   logic [MASK_W-1:0]   mask_ff,   mask_in;
   logic [RIGHTS_W-1:0] rights_ff, rights_in;
   logic                valid_ff,  valid_in;
   logic                match_ff,  match_in;
   logic                hit_ff,    hit_in;
   logic                eq_ff,     eq_in;

   always_comb begin
      key_in    = key_ff;
      data_in   = data_ff;
      bytes_in  = bytes_ff;
      mask_in   = mask_ff;
      rights_in = rights_ff;
      valid_in  = valid_ff;
      priority if (ctl.load) begin
         key_in    = new_key;
         data_in   = new_data;
         bytes_in  = new_bytes;
         mask_in   = new_mask;
         rights_in = new_rights;
         valid_in  = 1'b1;
      end else if (ctl.shift) begin
         key_in    = nbr_key;
         data_in   = nbr_data;
         bytes_in  = nbr_bytes;
         mask_in   = nbr_mask;
         rights_in = nbr_rights;
         valid_in  = nbr_valid;
      end else if (ctl.clear) begin
         valid_in  = 1'b0;
      end
   end

   // Gate with occupancy so empty slots never match.
   always_comb begin
      match_in = match_ff;
      hit_in   = hit_ff;
      eq_in    = eq_ff;
      if (ctl.cmp_en) begin
         match_in = occupied && (key_ff == cmp_key);
         hit_in   = occupied && (key_ff == cmp_key) && valid_ff;
         eq_in    = (rights_ff == cmp_rights);
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      data_ff   <= data_in;
      bytes_ff  <= bytes_in;
      mask_ff   <= mask_in;
      rights_ff <= rights_in;
      valid_ff  <= valid_in;
      match_ff  <= match_in;
      hit_ff    <= hit_in;
      eq_ff     <= eq_in;
   end

   assign key       = key_ff;
   assign data      = data_ff;
   assign nbytes    = bytes_ff;
   assign mask      = mask_ff;
   assign rights    = rights_ff;
   assign valid     = valid_ff;
   assign match     = match_ff;
   assign hit       = hit_ff;
   assign rights_eq = eq_ff;

endmodule

FILE: rtl/keyed_block_cache_fifo.sv
// Keyed block cache, fully associative, oldest-first eviction, top level.
// Sequence: accept the request and register it, key compare in every cell,
// update and response register load; the next request is accepted only back in
// idle, and a stalled response holds the update stage.
// Reset (synchronous, active high) empties the table and drops any response.
// Uses kbc_pkg, kbc_cell and kbc_pick.
module keyed_block_cache_fifo
   import kbc_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
   parameter int DATA_BYTES = DATA_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // block_key[31:0], payload[63:32], payload_bytes[66:64], mask_byte[74:67],
   // rights[106:75], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // stored_data[31:0], stored_bytes[34:32], stored_mask[42:35],
   // stored_rights[74:43], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status[2:0], found[3]
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // Keys compare on at most the width of the key field; data words hold at
   // most the bytes that fit the payload field.
   localparam int KW = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
   localparam int SB = (DATA_BYTES < PAYLOAD_W / 8) ? DATA_BYTES : PAYLOAD_W / 8;
   localparam int DW = SB * 8;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RSP_PAD_W = RSP_TDATA_W - RSP_FIELDS_W;

   // Request field offsets in tdata
   localparam int KEY_LO    = 0;
   localparam int PAY_LO    = KEY_LO + KEY_FIELD_W;
   localparam int NBYTES_LO = PAY_LO + PAYLOAD_W;
   localparam int MASK_LO   = NBYTES_LO + NBYTES_W;
   localparam int RIGHTS_LO = MASK_LO + MASK_W;

   // ---------------------------------------------------------------------
   // Sequencer and request hold registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   action_type          req_action_ff;
   logic [KW-1:0]       req_key_ff;
   logic [PAYLOAD_W-1:0] req_payload_ff;
   logic [NBYTES_W-1:0] req_nbytes_ff;
   logic [MASK_W-1:0]   req_mask_ff;
   logic [RIGHTS_W-1:0] req_rights_ff;

   logic [CW-1:0] count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [PAYLOAD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [NBYTES_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [RIGHTS_W-1:0]  rsp_rights_ff, rsp_rights_in;

   logic req_take;
   logic cmp_en;
   logic upd_fire;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      cmp_en     = 1'b0;
      upd_fire   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_LOOKUP: cmp_en     = 1'b1;
         ST_UPDATE: upd_fire   = !rsp_valid_ff || rsp_tready;
         default:   req_tready = 1'b0;
      endcase
   end

   assign req_take = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // New entry: saturate the byte count, mask the live bytes, zero the rest
   // ---------------------------------------------------------------------
   logic [NBYTES_W-1:0] nbytes_sat;
   logic [DW-1:0]       new_data;

   always_comb begin
      nbytes_sat = ({1'b0, req_nbytes_ff} > (NBYTES_W + 1)'(DATA_BYTES))
                   ? NBYTES_W'(DATA_BYTES) : req_nbytes_ff;
      for (int b = 0; b < SB; b++) begin
         new_data[b*8 +: 8] = (NBYTES_W'(b) < nbytes_sat)
                              ? (req_payload_ff[b*8 +: 8] ^ req_mask_ff) : 8'h00;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: slot 0 is the oldest; on eviction every cell takes the
   // entry of the cell above it and the top cell takes the new entry.
   // ---------------------------------------------------------------------
   cell_ctl_type        cell_ctl    [CAPACITY];
   logic [KW-1:0]       cell_key    [CAPACITY];
   logic [DW-1:0]       cell_data   [CAPACITY];
   logic [NBYTES_W-1:0] cell_bytes  [CAPACITY];
   logic [MASK_W-1:0]   cell_mask   [CAPACITY];
   logic [RIGHTS_W-1:0] cell_rights [CAPACITY];
   logic                cell_valid  [CAPACITY];
   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] hit_vec;
   logic [CAPACITY-1:0] eq_vec;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occupied[i] = (CW'(i) < count_ff);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KW-1:0]       nbr_key;
      logic [DW-1:0]       nbr_data;
      logic [NBYTES_W-1:0] nbr_bytes;
      logic [MASK_W-1:0]   nbr_mask;
      logic [RIGHTS_W-1:0] nbr_rights;
      logic                nbr_valid;

      if (i == CAPACITY - 1) begin : g_top
         // Top cell is always loaded on eviction; feed it the new entry.
         assign nbr_key    = req_key_ff;
         assign nbr_data   = new_data;
         assign nbr_bytes  = nbytes_sat;
         assign nbr_mask   = req_mask_ff;
         assign nbr_rights = req_rights_ff;
         assign nbr_valid  = 1'b1;
      end else begin : g_mid
         assign nbr_key    = cell_key[i+1];
         assign nbr_data   = cell_data[i+1];
         assign nbr_bytes  = cell_bytes[i+1];
         assign nbr_mask   = cell_mask[i+1];
         assign nbr_rights = cell_rights[i+1];
         assign nbr_valid  = cell_valid[i+1];
      end

      kbc_cell #(
         .KW (KW),
         .DW (DW)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .occupied   (occupied[i]),
         .cmp_key    (req_key_ff),
         .cmp_rights (req_rights_ff),
         .new_key    (req_key_ff),
         .new_data   (new_data),
         .new_bytes  (nbytes_sat),
         .new_mask   (req_mask_ff),
         .new_rights (req_rights_ff),
         .nbr_key    (nbr_key),
         .nbr_data   (nbr_data),
         .nbr_bytes  (nbr_bytes),
         .nbr_mask   (nbr_mask),
         .nbr_rights (nbr_rights),
         .nbr_valid  (nbr_valid),
         .key        (cell_key[i]),
         .data       (cell_data[i]),
         .nbytes     (cell_bytes[i]),
         .mask       (cell_mask[i]),
         .rights     (cell_rights[i]),
         .valid      (cell_valid[i]),
         .match      (match_vec[i]),
         .hit        (hit_vec[i]),
         .rights_eq  (eq_vec[i])
      );
   end

   // First valid match serves a get; first match of any kind serves put
   // and invalidate.
   logic [CAPACITY-1:0] hit_oh;
   logic [CAPACITY-1:0] match_oh;
   logic                hit_any;
   logic                match_any;

   kbc_pick #(.N(CAPACITY)) u_pick_hit (
      .match_vec (hit_vec),
      .first_oh  (hit_oh),
      .any       (hit_any)
   );

   kbc_pick #(.N(CAPACITY)) u_pick_match (
      .match_vec (match_vec),
      .first_oh  (match_oh),
      .any       (match_any)
   );

   // ---------------------------------------------------------------------
   // Update stage: decide the response and the cell strobes
   // ---------------------------------------------------------------------
   logic          full;
   logic          do_insert;
   logic          do_clear;
   logic [DW-1:0] rd_data;
   logic [NBYTES_W-1:0] rd_bytes;
   logic [MASK_W-1:0]   rd_mask;
   logic [RIGHTS_W-1:0] rd_rights;
   logic          sel_eq;
   status_type    upd_status;

   assign full = (count_ff == CW'(CAPACITY));

   // Read out the first hit: one-hot OR mux across the cells.
   always_comb begin
      rd_data   = '0;
      rd_bytes  = '0;
      rd_mask   = '0;
      rd_rights = '0;
      sel_eq    = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_oh[i]) begin
            rd_data   = rd_data   | cell_data[i];
            rd_bytes  = rd_bytes  | cell_bytes[i];
            rd_mask   = rd_mask   | cell_mask[i];
            rd_rights = rd_rights | cell_rights[i];
         end
         sel_eq = sel_eq | (match_oh[i] & eq_vec[i]);
      end
   end

   always_comb begin
      upd_status = RSP_MISS;
      do_insert  = 1'b0;
      do_clear   = 1'b0;
      unique case (req_action_ff)
         ACT_GET: begin
            if (hit_any) upd_status = RSP_HIT;
         end
         ACT_PUT: begin
            if (match_any) begin
               // Known key: rights mismatch drops the entry, else leave it.
               if (sel_eq) begin
                  upd_status = RSP_UNCHANGED;
               end else begin
                  upd_status = RSP_RIGHTS_INVAL;
                  do_clear   = 1'b1;
               end
            end else begin
               do_insert  = 1'b1;
               upd_status = full ? RSP_EVICTED : RSP_INSERTED;
            end
         end
         ACT_INVAL: begin
            if (match_any) begin
               upd_status = RSP_INVALIDATED;
               do_clear   = 1'b1;
            end else begin
               upd_status = RSP_INVAL_MISS;
            end
         end
         default: upd_status = RSP_MISS;
      endcase
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctl[i].cmp_en = cmp_en;
         cell_ctl[i].shift  = upd_fire && do_insert && full;
         cell_ctl[i].load   = upd_fire && do_insert &&
                              (full ? (i == CAPACITY - 1) : (count_ff == CW'(i)));
         cell_ctl[i].clear  = upd_fire && do_clear && match_oh[i];
      end
   end

   // Entry count: grow on insert into a free slot; eviction keeps it full.
   always_comb begin
      count_in = count_ff;
      if (upd_fire && do_insert && !full) count_in = count_ff + CW'(1);
   end

   // Response register: load on update, drop when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_rights_in = rsp_rights_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (upd_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = upd_status;
         rsp_found_in  = (upd_status == RSP_HIT);
         if (upd_status == RSP_HIT) begin
            rsp_data_in   = PAYLOAD_W'(rd_data);
            rsp_bytes_in  = rd_bytes;
            rsp_mask_in   = rd_mask;
            rsp_rights_in = rd_rights;
         end else begin
            rsp_data_in   = '0;
            rsp_bytes_in  = '0;
            rsp_mask_in   = '0;
            rsp_rights_in = '0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold the request for the compare and update stages.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff  <= action_type'(req_tuser[ACTION_W-1:0]);
         req_key_ff     <= req_tdata[KEY_LO +: KW];
         req_payload_ff <= req_tdata[PAY_LO +: PAYLOAD_W];
         req_nbytes_ff  <= req_tdata[NBYTES_LO +: NBYTES_W];
         req_mask_ff    <= req_tdata[MASK_LO +: MASK_W];
         req_rights_ff  <= req_tdata[RIGHTS_LO +: RIGHTS_W];
      end
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_rights_ff <= rsp_rights_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_rights_ff, rsp_mask_ff,
                        rsp_bytes_ff, rsp_data_ff};
   assign rsp_tuser  = {rsp_found_ff, rsp_status_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_found_is_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_found_ff == (rsp_status_ff == RSP_HIT)))
      else $error("found flag disagrees with status");

   a_hit_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_found_ff) |-> (count_ff != '0))
      else $error("hit reported on an empty table");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update stage");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench of keyed_block_cache_fifo: a table model predicts each response;
// directed, then random get/put/invalidate requests with random stalls on both sides.
// Depends on kbc_pkg and the RTL of keyed_block_cache_fifo.
module tb_top;
   import kbc_pkg::*;

   // The request kind left unused by the block; it must answer a miss.
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_REQUESTS = 1400;
   localparam int IDLE_PCT        = 27;

   typedef struct {
      logic [KEY_FIELD_W-1:0] key;
      logic [PAYLOAD_W-1:0]   data;
      logic [NBYTES_W-1:0]    nbytes;
      logic [MASK_W-1:0]      mask;
      logic [RIGHTS_W-1:0]    rights;
      logic                   valid;
   } table_slot_type;

   typedef struct {
      status_type           status;
      logic                 found;
      logic [PAYLOAD_W-1:0] data;
      logic [NBYTES_W-1:0]  nbytes;
      logic [MASK_W-1:0]    mask;
      logic [RIGHTS_W-1:0]  rights;
   } table_response_type;

   // Table model plus the queue of responses still owed by the block.
   class block_table_type;
      table_slot_type     slots[CAPACITY_DEF];
      int                 fill_level;
      table_response_type expected_rsps[$];
      int unsigned        mismatches;

      function new();
         fill_level = 0;
         mismatches = 0;
      endfunction

      // First slot holding the key, oldest first; -1 when there is none.
      function int find_key(logic [KEY_FIELD_W-1:0] key, bit need_valid);
         for (int i = 0; i < fill_level; i++)
            if (slots[i].key == key && (!need_valid || slots[i].valid))
               return i;
         return -1;
      endfunction

      // Apply one accepted request to the table and queue its response.
      function void note_request(logic [ACTION_W-1:0] action, logic [KEY_FIELD_W-1:0] key,
                                 logic [PAYLOAD_W-1:0] payload, logic [NBYTES_W-1:0] nbytes,
                                 logic [MASK_W-1:0] mask, logic [RIGHTS_W-1:0] rights);
         table_response_type rsp;
         int              slot;
         logic [NBYTES_W-1:0]  count;
         logic [PAYLOAD_W-1:0] word;
         rsp.status = RSP_MISS;
         rsp.found  = 1'b0;
         rsp.data   = '0;
         rsp.nbytes = '0;
         rsp.mask   = '0;
         rsp.rights = '0;
         case (action)
            ACT_GET: begin
               slot = find_key(key, 1'b1);
               if (slot >= 0) begin
                  rsp.status = RSP_HIT;
                  rsp.found  = 1'b1;
                  rsp.data   = slots[slot].data;
                  rsp.nbytes = slots[slot].nbytes;
                  rsp.mask   = slots[slot].mask;
                  rsp.rights = slots[slot].rights;
               end
            end
            ACT_PUT: begin
               slot = find_key(key, 1'b0);
               if (slot >= 0) begin
                  // known key: only the rights are looked at
                  if (slots[slot].rights != rights) begin
                     slots[slot].valid = 1'b0;
                     rsp.status = RSP_RIGHTS_INVAL;
                  end else begin
                     rsp.status = RSP_UNCHANGED;
                  end
               end else begin
                  rsp.status = RSP_INSERTED;
                  if (fill_level >= CAPACITY_DEF) begin
                     // drop the oldest slot, valid or not, and shift down
                     for (int i = 1; i < CAPACITY_DEF; i++)
                        slots[i-1] = slots[i];
                     fill_level = CAPACITY_DEF - 1;
                     rsp.status = RSP_EVICTED;
                  end
                  count = (nbytes > DATA_BYTES_DEF) ? NBYTES_W'(DATA_BYTES_DEF) : nbytes;
                  word  = '0;
                  for (int i = 0; i < count; i++)
                     word[8*i +: 8] = payload[8*i +: 8] ^ mask;
                  slots[fill_level].key    = key;
                  slots[fill_level].data   = word;
                  slots[fill_level].nbytes = count;
                  slots[fill_level].mask   = mask;
                  slots[fill_level].rights = rights;
                  slots[fill_level].valid  = 1'b1;
                  fill_level++;
               end
            end
            ACT_INVAL: begin
               slot = find_key(key, 1'b0);
               if (slot >= 0) begin
                  slots[slot].valid = 1'b0;
                  rsp.status = RSP_INVALIDATED;
               end else begin
                  rsp.status = RSP_INVAL_MISS;
               end
            end
            default: ;
         endcase
         expected_rsps.push_back(rsp);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      endtask

      // Compare one accepted response with the oldest expectation.
      task check_response(logic [RSP_TUSER_W-1:0] tuser, logic [RSP_TDATA_W-1:0] tdata);
         table_response_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request outstanding", 32'(tuser), 32'd0);
            return;
         end
         want = expected_rsps.pop_front();
         if (tuser[2:0] !== want.status)
            report_mismatch("status", 32'(tuser[2:0]), 32'(want.status));
         if (tuser[3] !== want.found)
            report_mismatch("found", 32'(tuser[3]), 32'(want.found));
         if (tdata[31:0] !== want.data)
            report_mismatch("stored_data", tdata[31:0], want.data);
         if (tdata[34:32] !== want.nbytes)
            report_mismatch("stored_bytes", 32'(tdata[34:32]), 32'(want.nbytes));
         if (tdata[42:35] !== want.mask)
            report_mismatch("stored_mask", 32'(tdata[42:35]), 32'(want.mask));
         if (tdata[74:43] !== want.rights)
            report_mismatch("stored_rights", tdata[74:43], want.rights);
         if (tdata[RSP_TDATA_W-1:RSP_FIELDS_W] !== '0)
            report_mismatch("tdata fill", 32'(tdata[RSP_TDATA_W-1:RSP_FIELDS_W]), 32'd0);
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // block_key, payload, payload_bytes, mask_byte, rights from bit 0 up
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // action
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // stored_data, stored_bytes, stored_mask, stored_rights from bit 0 up
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status, found
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // High while neither side may idle.
   logic        quiet_stretch = 1'b0;
   int unsigned cycle_count   = 0;

   // Keys and rights drawn from small pools so that hits, known-key puts and
   // evictions happen often; a share of fully random values covers every bit.
   logic [KEY_FIELD_W-1:0] key_pool[12];
   logic [RIGHTS_W-1:0]    rights_pool[3];

   block_table_type table_model = new();

   keyed_block_cache_fifo u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: end the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: check on each handshake, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         table_model.check_response(rsp_tuser, rsp_tdata);
      rsp_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
   end

   // Present one request, hold it until accepted, then maybe idle a few cycles.
   // Valid stays high across back-to-back requests.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [KEY_FIELD_W-1:0] key,
                               input logic [PAYLOAD_W-1:0] payload,
                               input logic [NBYTES_W-1:0] nbytes,
                               input logic [MASK_W-1:0] mask,
                               input logic [RIGHTS_W-1:0] rights);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(REQ_TDATA_W-REQ_FIELDS_W){1'b0}}, rights, mask, nbytes, payload, key};
      do @(posedge clock); while (!req_tready);
      table_model.note_request(action, key, payload, nbytes, mask, rights);
      if (!quiet_stretch && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every outstanding response is back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (table_model.expected_rsps.size() != 0);
   endtask

   task automatic send_random_request();
      int unsigned            pick;
      logic [ACTION_W-1:0]    action;
      logic [KEY_FIELD_W-1:0] key;
      logic [RIGHTS_W-1:0]    rights;
      pick = $urandom_range(99);
      if (pick < 40)
         action = ACT_GET;
      else if (pick < 75)
         action = ACT_PUT;
      else if (pick < 94)
         action = ACT_INVAL;
      else
         action = ACT_UNUSED;
      key    = ($urandom_range(99) < 10) ? $urandom() : key_pool[$urandom_range(11)];
      rights = ($urandom_range(99) < 25) ? $urandom() : rights_pool[$urandom_range(2)];
      send_request(action, key, $urandom(), NBYTES_W'($urandom_range(7)),
                   MASK_W'($urandom_range(255)), rights);
   endtask

   initial begin
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++)
         key_pool[i] = $urandom();
      rights_pool[0] = '0;
      rights_pool[1] = '1;
      rights_pool[2] = $urandom();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty table: get miss, invalidate miss, unused request kind.
      send_request(ACT_GET, '0, '0, '0, '0, '0);
      send_request(ACT_INVAL, '1, '1, '1, '1, '1);
      send_request(ACT_UNUSED, '0, '1, '1, '1, '1);
      // Extremes: byte count over the limit saturates; zero bytes stores nothing.
      send_request(ACT_PUT, '0, '1, 3'd7, 8'h00, '0);
      send_request(ACT_PUT, '1, '0, 3'd0, 8'hFF, '1);
      send_request(ACT_GET, '0, '0, '0, '0, '0);
      send_request(ACT_GET, '1, '0, '0, '0, '0);
      // Known key: same rights leave it, other rights invalidate it.
      send_request(ACT_PUT, '0, 32'h1111_1111, 3'd2, 8'h33, '0);
      send_request(ACT_PUT, '0, 32'h1111_1111, 3'd2, 8'h33, 32'h1);
      send_request(ACT_GET, '0, '0, '0, '0, '0);
      // Same rights on an invalid entry keep it invalid.
      send_request(ACT_PUT, '0, 32'h2222_2222, 3'd4, 8'h44, '0);
      send_request(ACT_GET, '0, '0, '0, '0, '0);
      // Fill the table; byte counts walk through 1..4, one over the limit and zero.
      for (int i = 1; i <= 6; i++)
         send_request(ACT_PUT, KEY_FIELD_W'(i), 32'h1234_5678 + i, NBYTES_W'(i % 6),
                      8'h5A, 32'hA5A5_0000 | i);
      // Full table: the invalid oldest entry ages out.
      send_request(ACT_PUT, 32'd7, 32'hDEAD_BEEF, 3'd4, 8'hC3, 32'h7);
      send_request(ACT_GET, '0, '0, '0, '0, '0);
      send_request(ACT_INVAL, 32'd3, '0, '0, '0, '0);
      send_request(ACT_GET, 32'd3, '0, '0, '0, '0);
      send_request(ACT_PUT, 32'd3, 32'hFFFF_0000, 3'd3, 8'h01, 32'hA5A5_0003);
      send_request(ACT_PUT, 32'd8, 32'h0F0F_0F0F, 3'd4, 8'hF0, 32'h8);
      send_request(ACT_GET, 32'd7, '0, '0, '0, '0);
      send_request(ACT_GET, '1, '0, '0, '0, '0);

      // Hold off until the table is quiet before the random part.
      wait_for_responses();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         quiet_stretch <= (n >= 600 && n < 850);
         if (n == 1000)
            wait_for_responses();
         send_random_request();
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (table_model.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
